[rtl/core/gcpd_pkg.sv]
// gcpd_pkg: shared widths, register indexes and size helpers for the gray code pixel decoder
`default_nettype none
package gcpd_pkg;

  localparam int MAX_AXIS_BITS = 12;
  localparam int SIZE_W        = MAX_AXIS_BITS + 1;
  localparam int COORD_W       = MAX_AXIS_BITS;
  localparam int NBITS_W       = $clog2(MAX_AXIS_BITS + 1);
  localparam int PLANE_W       = $clog2(2 * MAX_AXIS_BITS + 1);
  localparam int SUM_W         = COORD_W + PLANE_W;
  localparam int SAMPLE_W      = 8;
  localparam int THRESH_W      = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd32;
  localparam logic [SIZE_W-1:0]   WIDTH_RESET     = 13'd240;
  localparam logic [SIZE_W-1:0]   HEIGHT_RESET    = 13'd135;

  localparam logic [SIZE_W-1:0] SIZE_TOP = SIZE_W'(1) << MAX_AXIS_BITS;

  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [NBITS_W-1:0] nbits_t;

  // size limited to 1 .. 2^MAX_AXIS_BITS
  function automatic size_t clamp_size(input size_t s);
    size_t r;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_TOP) r = SIZE_TOP;
    else r = s;
    return r;
  endfunction

  // number of planes for an axis: bit length of size minus one
  function automatic nbits_t axis_bits(input size_t s);
    size_t  m;
    nbits_t n;
    m = s - SIZE_W'(1);
    n = '0;
    for (int k = 0; k < MAX_AXIS_BITS; k++) begin
      if (m[k]) n = NBITS_W'(k + 1);
    end
    return n;
  endfunction

  // centring shift: (2^n - size) >> 1
  function automatic size_t center_shift(input nbits_t n, input size_t s);
    size_t full;
    full = (SIZE_W'(1) << n) - s;
    return full >> 1;
  endfunction

endpackage
`default_nettype wire

[rtl/core/gray_code_pixel_decoder_core.sv]
// gray_code_pixel_decoder_core: per-pixel structured-light gray code decoder
//
// Input channel (in_valid/in_ready) carries one pattern pair per transfer:
// pattern and inverse grey samples plus a region bit. A frame is the column
// planes followed by the row planes, their counts set by the projector width
// and height registers. The last pair of a frame yields one result on the
// output channel (out_valid/out_ready): column, row and a valid flag.
// Latency: the result is shown the cycle after the last pair's transfer.
// Throughput: one pair per cycle while in_ready is high; the plane state
// and the result register update in the same cycle as the transfer.
// A waiting result does not block input while out_ready is high in the same
// cycle; when the receiver stalls, in_ready drops only while a result is
// held and not taken.
// Reset clears the frame state, drops out_valid and loads the registers
// with threshold 32, width 240, height 135.
// Configuration writes take effect at once; the user is to make them between
// frames or while the input is idle, which the block itself does not enforce.
`default_nettype none
module gray_code_pixel_decoder_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [gcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [gcpd_pkg::SAMPLE_W-1:0]   pattern_sample,
  input  wire logic [gcpd_pkg::SAMPLE_W-1:0]   inverse_sample,
  input  wire logic                            in_region,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [gcpd_pkg::COORD_W-1:0]         proj_column,
  output logic [gcpd_pkg::COORD_W-1:0]         proj_row,
  output logic                                 pixel_valid
);
  import gcpd_pkg::*;

  logic [THRESH_W-1:0] decode_threshold;
  size_t               col_limit;
  size_t               row_limit;

  logic [PLANE_W-1:0]  plane_index;
  logic                binary_bit;
  logic [SUM_W-1:0]    column_sum;
  logic [SUM_W-1:0]    row_sum;
  logic                contrast_seen;

  logic [PLANE_W-1:0]  plane_index_next;
  logic                binary_bit_next;
  logic [SUM_W-1:0]    column_sum_next;
  logic [SUM_W-1:0]    row_sum_next;
  logic                contrast_seen_next;

  size_t               w_clamp, h_clamp, cshift, rshift;
  nbits_t              ncol, nrow;
  logic [PLANE_W-1:0]  total;
  logic [SAMPLE_W-1:0] p_s, q_s, diff;
  logic                gray_bit;
  logic                in_xfer;
  logic                frame_end;
  logic [PLANE_W-1:0]  row_i;
  logic [NBITS_W-1:0]  wsh;
  logic [SUM_W-1:0]    col_full, row_full;
  logic                res_valid;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    w_clamp = clamp_size(col_limit);
    h_clamp = clamp_size(row_limit);
    ncol    = axis_bits(w_clamp);
    nrow    = axis_bits(h_clamp);
    total   = PLANE_W'(ncol) + PLANE_W'(nrow);
    cshift  = center_shift(ncol, w_clamp);
    rshift  = center_shift(nrow, h_clamp);
  end

  always_comb begin
    p_s      = in_region ? pattern_sample : '0;
    q_s      = in_region ? inverse_sample : '0;
    gray_bit = (p_s >= q_s);
    diff     = gray_bit ? (p_s - q_s) : (q_s - p_s);
    row_i    = plane_index - PLANE_W'(ncol);

    contrast_seen_next = contrast_seen || (diff >= decode_threshold);
    binary_bit_next    = binary_bit;
    column_sum_next    = column_sum;
    row_sum_next       = row_sum;
    wsh                = '0;

    if (plane_index < PLANE_W'(ncol)) begin
      binary_bit_next = (plane_index == '0) ? gray_bit : (binary_bit ^ gray_bit);
      wsh = NBITS_W'(PLANE_W'(ncol) - PLANE_W'(1) - plane_index);
      if (binary_bit_next) column_sum_next = column_sum + (SUM_W'(1) << wsh);
    end else if (plane_index < total) begin
      binary_bit_next = (row_i == '0) ? gray_bit : (binary_bit ^ gray_bit);
      wsh = NBITS_W'(PLANE_W'(nrow) - PLANE_W'(1) - row_i);
      if (binary_bit_next) row_sum_next = row_sum + (SUM_W'(1) << wsh);
    end

    frame_end        = (total == '0) || !((plane_index + PLANE_W'(1)) < total);
    plane_index_next = plane_index + PLANE_W'(1);

    // saturating subtract of the centring shift
    col_full = (column_sum_next > SUM_W'(cshift)) ? column_sum_next - SUM_W'(cshift) : '0;
    row_full = (row_sum_next > SUM_W'(rshift)) ? row_sum_next - SUM_W'(rshift) : '0;
    res_valid = contrast_seen_next && (col_full < SUM_W'(w_clamp))
                && (row_full < SUM_W'(h_clamp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_threshold <= THRESHOLD_RESET;
      col_limit        <= WIDTH_RESET;
      row_limit        <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: decode_threshold <= cfg_data[THRESH_W-1:0];
        REG_WIDTH:     col_limit        <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:    row_limit        <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_index   <= '0;
      binary_bit    <= 1'b0;
      column_sum    <= '0;
      row_sum       <= '0;
      contrast_seen <= 1'b0;
    end else if (in_xfer) begin
      if (frame_end) begin
        plane_index   <= '0;
        binary_bit    <= 1'b0;
        column_sum    <= '0;
        row_sum       <= '0;
        contrast_seen <= 1'b0;
      end else begin
        plane_index   <= plane_index_next;
        binary_bit    <= binary_bit_next;
        column_sum    <= column_sum_next;
        row_sum       <= row_sum_next;
        contrast_seen <= contrast_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && frame_end) begin
      proj_column <= res_valid ? col_full[COORD_W-1:0] : '0;
      proj_row    <= res_valid ? row_full[COORD_W-1:0] : '0;
      pixel_valid <= res_valid;
    end
  end

  // an invalid pixel always carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> proj_column == '0 && proj_row == '0)
    else $error("invalid pixel with nonzero coordinates");

  // plane counter stays inside the largest frame
  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    plane_index < PLANE_W'(2 * MAX_AXIS_BITS))
    else $error("plane index out of range");

  // a mid-frame transfer advances the plane counter by one
  a_plane_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !frame_end |=> plane_index == $past(plane_index) + PLANE_W'(1))
    else $error("plane index did not advance");

  // the last plane of a frame produces a result and restarts the frame
  a_frame_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && frame_end |=> out_valid && plane_index == '0)
    else $error("frame end without result");

endmodule
`default_nettype wire

[tb/gcpd_decode_check.sv]
`timescale 1ns / 1ps
// gcpd_decode_check: follows register writes, predicts each decoded pixel and checks every result
module gcpd_decode_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [gcpd_pkg::SAMPLE_W-1:0]   pattern_sample,
  input  logic [gcpd_pkg::SAMPLE_W-1:0]   inverse_sample,
  input  logic                            in_region,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [gcpd_pkg::COORD_W-1:0]    proj_column,
  input  logic [gcpd_pkg::COORD_W-1:0]    proj_row,
  input  logic                            pixel_valid,
  output int                              outstanding,
  output int                              mismatches,
  output int                              pixels_seen,
  output int                              pixels_valid
);
  import gcpd_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               hit;
  } pixel_fix_t;

  logic [THRESH_W-1:0] threshold;
  logic [SIZE_W-1:0]   width_cfg;
  logic [SIZE_W-1:0]   height_cfg;
  int unsigned         plane;
  int unsigned         col_acc;
  int unsigned         row_acc;
  bit                  gray_run;
  bit                  contrast;
  pixel_fix_t          pending_pixels[$];
  pixel_fix_t          head;
  int                  fail_count = 0;
  int                  seen_count = 0;
  int                  valid_count = 0;

  assign mismatches   = fail_count;
  assign pixels_seen  = seen_count;
  assign pixels_valid = valid_count;

  function automatic int unsigned fit_dim(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > (1 << MAX_AXIS_BITS)) return 1 << MAX_AXIS_BITS;
    return s;
  endfunction

  function automatic int unsigned plane_count(input int unsigned s);
    int unsigned n;
    n = 0;
    while (n < MAX_AXIS_BITS && (32'd1 << n) < s) n++;
    return n;
  endfunction

  task automatic restart_frame();
    plane    = 0;
    gray_run = 1'b0;
    col_acc  = 0;
    row_acc  = 0;
    contrast = 1'b0;
  endtask

  task automatic decode_pair(input logic [SAMPLE_W-1:0] pat, input logic [SAMPLE_W-1:0] inv,
                             input logic region);
    int unsigned w, h, ncol, nrow, planes, p, q, diff, col, row;
    int unsigned col_offset, row_offset;
    bit          b;
    pixel_fix_t  fix;
    w      = fit_dim(width_cfg);
    h      = fit_dim(height_cfg);
    ncol   = plane_count(w);
    nrow   = plane_count(h);
    planes = ncol + nrow;
    p      = region ? pat : 0;
    q      = region ? inv : 0;
    b      = (p >= q);
    diff   = b ? p - q : q - p;
    if (diff >= threshold) contrast = 1'b1;
    // gray to binary by running xor, msb first per axis
    if (plane < ncol) begin
      gray_run = (plane == 0) ? b : gray_run ^ b;
      if (gray_run) col_acc += 32'd1 << (ncol - 1 - plane);
    end else if (plane < planes) begin
      gray_run = (plane == ncol) ? b : gray_run ^ b;
      if (gray_run) row_acc += 32'd1 << (planes - 1 - plane);
    end
    if (planes != 0 && plane + 1 < planes) begin
      plane++;
    end else begin
      col_offset = ((32'd1 << ncol) - w) >> 1;
      row_offset = ((32'd1 << nrow) - h) >> 1;
      col        = (col_acc > col_offset) ? col_acc - col_offset : 0;
      row        = (row_acc > row_offset) ? row_acc - row_offset : 0;
      fix.hit    = contrast && col <= w - 1 && row <= h - 1;
      fix.column = fix.hit ? COORD_W'(col) : '0;
      fix.row    = fix.hit ? COORD_W'(row) : '0;
      pending_pixels.insert(pending_pixels.size(), fix);
      restart_frame();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold  = THRESHOLD_RESET;
      width_cfg  = WIDTH_RESET;
      height_cfg = HEIGHT_RESET;
      restart_frame();
      pending_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("result transfer with no pixel pending: proj_column %0d proj_row %0d pixel_valid %0b",
                 proj_column, proj_row, pixel_valid);
          fail_count++;
        end else begin
          head = pending_pixels.pop_front();
          if (proj_column !== head.column) begin
            $error("proj_column: expected %0d, actual %0d", head.column, proj_column);
            fail_count++;
          end
          if (proj_row !== head.row) begin
            $error("proj_row: expected %0d, actual %0d", head.row, proj_row);
            fail_count++;
          end
          if (pixel_valid !== head.hit) begin
            $error("pixel_valid: expected %0b, actual %0b", head.hit, pixel_valid);
            fail_count++;
          end
          seen_count++;
          if (head.hit) valid_count++;
        end
      end
      // a transfer in the same cycle as a write still sees the old registers
      if (in_valid && in_ready) decode_pair(pattern_sample, inverse_sample, in_region);
      if (cfg_write) begin
        case (cfg_index)
          REG_THRESHOLD: threshold = cfg_data[THRESH_W-1:0];
          REG_WIDTH:     width_cfg = cfg_data;
          REG_HEIGHT:    height_cfg = cfg_data;
          default:       ;
        endcase
      end
    end
    outstanding <= pending_pixels.size();
  end

endmodule

[tb/gray_code_pixel_decoder_core_test.sv]
`timescale 1ns / 1ps
// gray_code_pixel_decoder_core_test: drives pattern pairs and registers, idles both sides, gives the verdict
module gray_code_pixel_decoder_core_test;
  import gcpd_pkg::*;

  localparam int TOTAL_PAIRS = 920;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   pattern_sample;
  logic [SAMPLE_W-1:0]   inverse_sample;
  logic                  in_region;
  logic                  out_valid;
  logic                  out_ready;
  logic [COORD_W-1:0]    proj_column;
  logic [COORD_W-1:0]    proj_row;
  logic                  pixel_valid;

  int outstanding;
  int mismatches;
  int pixels_seen;
  int pixels_valid;
  int pairs_sent     = 0;
  int settings_used  = 0;
  int cur_w          = WIDTH_RESET;
  int cur_h          = HEIGHT_RESET;
  int quiet_cycles   = 0;
  bit tx_calm        = 1'b0;
  bit rx_calm        = 1'b0;
  bit stall_test     = 1'b0;
  bit long_hold_done = 1'b0;

  always #4 clk = ~clk;

  gray_code_pixel_decoder_core dut (.*);

  gcpd_decode_check decode_check (.*);

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 12) return 1;
    if (r < 17) return $urandom_range(4097, 8191);
    if (r < 22) return $urandom_range(257, 4096);
    return $urandom_range(2, 48);
  endfunction

  function automatic int clamp_dim(input int s);
    if (s == 0) return 1;
    if (s > (1 << MAX_AXIS_BITS)) return 1 << MAX_AXIS_BITS;
    return s;
  endfunction

  function automatic int frame_length();
    int n;
    n = $clog2(clamp_dim(cur_w)) + $clog2(clamp_dim(cur_h));
    return (n == 0) ? 1 : n;
  endfunction

  task automatic write_config(input int thr, input int w, input int h);
    cfg_write <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_w = w;
    cur_h = h;
    settings_used++;
  endtask

  task automatic send_pair(input logic [SAMPLE_W-1:0] pat, input logic [SAMPLE_W-1:0] inv,
                           input logic region);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pattern_sample <= pat;
    inverse_sample <= inv;
    in_region      <= region;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic send_plane(input bit code_bit);
    int lo, hi;
    bit region;
    lo     = $urandom_range(0, 200);
    hi     = lo + $urandom_range(0, 255 - lo);
    region = ($urandom_range(0, 19) != 0);
    if (code_bit) send_pair(SAMPLE_W'(hi), SAMPLE_W'(lo), region);
    else send_pair(SAMPLE_W'(lo), SAMPLE_W'(hi), region);
  endtask

  // well-formed frame: gray code of a target pixel, mostly inside the projector
  task automatic send_code_frame();
    int w, h, ncol, nrow, cv, rv, code;
    w    = clamp_dim(cur_w);
    h    = clamp_dim(cur_h);
    ncol = $clog2(w);
    nrow = $clog2(h);
    if ($urandom_range(0, 9) == 0) cv = $urandom_range(0, (1 << ncol) - 1);
    else cv = $urandom_range(0, w - 1) + (((1 << ncol) - w) >> 1);
    if ($urandom_range(0, 9) == 0) rv = $urandom_range(0, (1 << nrow) - 1);
    else rv = $urandom_range(0, h - 1) + (((1 << nrow) - h) >> 1);
    code = cv ^ (cv >> 1);
    for (int i = ncol - 1; i >= 0; i--) send_plane(code[i]);
    code = rv ^ (rv >> 1);
    for (int i = nrow - 1; i >= 0; i--) send_plane(code[i]);
    if (ncol + nrow == 0) send_plane(1'b1);
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_pair(SAMPLE_W'($urandom_range(0, 255)), SAMPLE_W'($urandom_range(0, 255)),
                $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_test && !long_hold_done && out_valid) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap(rx_calm);
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int  phase_end;
    int  planes;
    int  phase;
    int  thr;
    bit  pressure;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_THRESHOLD;
    cfg_data       = '0;
    in_valid       = 1'b0;
    pattern_sample = '0;
    inverse_sample = '0;
    in_region      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    send_code_frame();
    finish_phase();
    // zero sizes, no planes: every pair is a pixel
    write_config(0, 0, 0);
    send_pair(8'd0, 8'd0, 1'b1);
    send_pair(8'd255, 8'd0, 1'b0);
    finish_phase();
    write_config(255, 1, 1);
    send_pair(8'd255, 8'd0, 1'b1);
    send_pair(8'd254, 8'd0, 1'b1);
    send_pair(8'd0, 8'd255, 1'b1);
    finish_phase();
    // size shrunk in the middle of a frame
    write_config(8, 8, 2);
    send_pair(8'd200, 8'd10, 1'b1);
    send_pair(8'd10, 8'd200, 1'b1);
    finish_phase();
    write_config(8, 1, 2);
    send_pair(8'd255, 8'd255, 1'b1);

    phase = 0;
    while (pairs_sent < TOTAL_PAIRS) begin
      finish_phase();
      pressure = (phase == 2);
      tx_calm  = pressure || ($urandom_range(0, 4) == 0);
      rx_calm    <= !pressure && ($urandom_range(0, 4) == 0);
      stall_test <= pressure;
      if ($urandom_range(0, 3) == 0) thr = $urandom_range(0, 1) ? 255 : 0;
      else thr = $urandom_range(0, 255);
      if (phase == 0) write_config(255, 8191, 4097);
      else if (phase == 1) write_config(0, 4096, 2);
      else if (pressure) write_config(thr, 1, 1);
      else write_config(thr, pick_size(), pick_size());
      if (pressure) begin
        send_noise(40);
      end else begin
        phase_end = pairs_sent + $urandom_range(30, 90);
        while (pairs_sent < phase_end) begin
          if ($urandom_range(0, 3) == 0) send_noise(frame_length());
          else send_code_frame();
        end
        planes = frame_length();
        if (planes > 1 && $urandom_range(0, 5) == 0) send_noise($urandom_range(1, planes - 1));
      end
      phase++;
    end
    finish_phase();
    repeat (8) @(posedge clk);

    $display("%0d pattern pairs under %0d register settings gave %0d pixels, %0d of them valid",
             pairs_sent, settings_used, pixels_seen, pixels_valid);
    $display("run included zero, one and oversized projector sizes, size changes mid-frame and a long output stall");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gcpd_pkg.sv
rtl/core/gray_code_pixel_decoder_core.sv
tb/gcpd_decode_check.sv
tb/gray_code_pixel_decoder_core_test.sv
